// ===== sv/rfv_pkg.sv =====
package rfv_pkg;

   localparam int QueueDepth = 2;

   localparam int DataW    = 64;
   localparam int HalfW    = 32;
   localparam int RegIdxW  = 5;
   localparam int FlagW    = 4;
   localparam int NumRegs  = 32;
   localparam logic [RegIdxW-1:0] SpSlot = 5'd31;

   typedef enum logic [1:0] {
      OP_READ      = 2'd0,
      OP_WRITE     = 2'd1,
      OP_SET_FLAGS = 2'd2,
      OP_TEST      = 2'd3
   } op_type;

   // view code fifteen is unused and falls into the default arm
   typedef enum logic [3:0] {
      VIEW_W32     = 4'd0,
      VIEW_X64     = 4'd1,
      VIEW_SP      = 4'd2,
      VIEW_ZERO    = 4'd3,
      VIEW_PC      = 4'd4,
      VIEW_TPIDR   = 4'd5,
      VIEW_TPIDRRO = 4'd6,
      VIEW_FPCR    = 4'd7,
      VIEW_FPSR    = 4'd8,
      VIEW_S       = 4'd9,
      VIEW_D       = 4'd10,
      VIEW_Q       = 4'd11,
      VIEW_V8B     = 4'd12,
      VIEW_V2D     = 4'd13,
      VIEW_VDELEM  = 4'd14
   } view_type;

   typedef enum logic [3:0] {
      CC_EQ = 4'd0,
      CC_NE = 4'd1,
      CC_HS = 4'd2,
      CC_LO = 4'd3,
      CC_MI = 4'd4,
      CC_PL = 4'd5,
      CC_VS = 4'd6,
      CC_VC = 4'd7,
      CC_HI = 4'd8,
      CC_LS = 4'd9,
      CC_GE = 4'd10,
      CC_LT = 4'd11,
      CC_GT = 4'd12,
      CC_LE = 4'd13,
      CC_AL = 4'd14,
      CC_NV = 4'd15
   } cond_type;

   // what the back end has to touch for one transaction
   typedef enum logic [3:0] {
      KIND_NONE    = 4'd0,
      KIND_GP      = 4'd1,
      KIND_PC      = 4'd2,
      KIND_TPIDR   = 4'd3,
      KIND_TPIDRRO = 4'd4,
      KIND_FPCR    = 4'd5,
      KIND_FPSR    = 4'd6,
      KIND_VEC     = 4'd7,
      KIND_FLAGS   = 4'd8,
      KIND_COND    = 4'd9,
      KIND_FAULT   = 4'd10
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic               wr;
      logic [RegIdxW-1:0] addr;      // gp register or vector row
      logic               elem_sel;  // element returned in read_elem0
      logic               two;       // read returns both elements
      logic               narrow;    // read value zero-extended from 32 bits
      logic               we0;
      logic               we1;
      logic [DataW-1:0]   d0;
      logic [DataW-1:0]   d1;
      logic [FlagW-1:0]   arg;       // new flags or condition code
   } cmd_type;

endpackage

// ===== sv/rfv_if.sv =====
interface rfv_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [3:0]  view;
   logic [4:0]  reg_index;
   logic        element_index;
   logic [63:0] write_elem0;
   logic [63:0] write_elem1;
   logic [3:0]  nzcv_in;
   logic [3:0]  condition_code;

   modport source (
      output valid, op, view, reg_index, element_index, write_elem0, write_elem1,
             nzcv_in, condition_code,
      input  ready
   );
   modport sink (
      input  valid, op, view, reg_index, element_index, write_elem0, write_elem1,
             nzcv_in, condition_code,
      output ready
   );
endinterface

interface rfv_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] read_elem0;
   logic [63:0] read_elem1;
   logic        condition_true;
   logic        fault;

   modport source (
      output valid, read_elem0, read_elem1, condition_true, fault,
      input  ready
   );
   modport sink (
      input  valid, read_elem0, read_elem1, condition_true, fault,
      output ready
   );
endinterface

// ===== sv/rfv_front.sv =====
module rfv_front import rfv_pkg::*; (
   rfv_req_if.sink  req_ch,
   output logic     push_valid,
   input  logic     push_ready,
   output cmd_type  push_cmd
);

   logic [DataW-1:0] d0_lo;

   assign d0_lo = {{(DataW-HalfW){1'b0}}, req_ch.write_elem0[HalfW-1:0]};

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

   always_comb begin
      push_cmd          = '0;
      push_cmd.kind     = KIND_NONE;
      push_cmd.wr       = (op_type'(req_ch.op) == OP_WRITE);
      push_cmd.addr     = req_ch.reg_index;
      push_cmd.d0       = req_ch.write_elem0;
      push_cmd.arg      = req_ch.condition_code;
      unique case (op_type'(req_ch.op))
         OP_SET_FLAGS: begin
            push_cmd.kind = KIND_FLAGS;
            push_cmd.arg  = req_ch.nzcv_in;
         end
         OP_TEST: begin
            push_cmd.kind = KIND_COND;
         end
         OP_READ, OP_WRITE: begin
            unique case (view_type'(req_ch.view))
               VIEW_W32, VIEW_X64: begin
                  if (req_ch.reg_index == SpSlot) begin
                     push_cmd.kind = KIND_FAULT;
                  end else begin
                     push_cmd.kind   = KIND_GP;
                     push_cmd.narrow = (view_type'(req_ch.view) == VIEW_W32);
                     if (view_type'(req_ch.view) == VIEW_W32) begin
                        push_cmd.d0 = d0_lo;
                     end
                  end
               end
               VIEW_SP: begin
                  push_cmd.kind = KIND_GP;
                  push_cmd.addr = SpSlot;
               end
               VIEW_ZERO:    push_cmd.kind = KIND_NONE;
               VIEW_PC:      push_cmd.kind = KIND_PC;
               VIEW_TPIDR:   push_cmd.kind = KIND_TPIDR;
               VIEW_TPIDRRO: push_cmd.kind = KIND_TPIDRRO;
               VIEW_FPCR:    push_cmd.kind = KIND_FPCR;
               VIEW_FPSR:    push_cmd.kind = KIND_FPSR;
               VIEW_S: begin
                  push_cmd.kind   = KIND_VEC;
                  push_cmd.narrow = 1'b1;
                  push_cmd.d0     = d0_lo;
                  push_cmd.we0    = 1'b1;
                  push_cmd.we1    = 1'b1;
               end
               VIEW_D, VIEW_V8B: begin
                  push_cmd.kind = KIND_VEC;
                  push_cmd.we0  = 1'b1;
                  push_cmd.we1  = 1'b1;
               end
               VIEW_Q: begin
                  push_cmd.kind = KIND_VEC;
                  push_cmd.two  = 1'b1;
                  push_cmd.we0  = 1'b1;
                  push_cmd.we1  = 1'b1;
                  push_cmd.d1   = req_ch.write_elem1;
               end
               VIEW_V2D: begin
                  push_cmd.kind = KIND_VEC;
                  push_cmd.two  = 1'b1;
                  push_cmd.we0  = 1'b1;
                  push_cmd.we1  = 1'b1;
                  push_cmd.d1   = req_ch.write_elem0;
               end
               VIEW_VDELEM: begin
                  push_cmd.kind     = KIND_VEC;
                  push_cmd.elem_sel = req_ch.element_index;
                  push_cmd.we0      = ~req_ch.element_index;
                  push_cmd.we1      = req_ch.element_index;
                  push_cmd.d1       = req_ch.write_elem0;
               end
               default: push_cmd.kind = KIND_FAULT;
            endcase
         end
         default: push_cmd.kind = KIND_FAULT;
      endcase
   end

endmodule

// ===== sv/rfv_queue.sv =====
module rfv_queue import rfv_pkg::*; #(
   parameter int DEPTH = QueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   cmd_type         slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push, pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/rfv_back.sv =====
module rfv_back import rfv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  cmd_type   pop_cmd,
   rfv_rsp_if.source rsp_ch
);

   // architectural state
   logic [DataW-1:0] gp_ff [NumRegs];
   logic [DataW-1:0] pc_ff;
   logic [DataW-1:0] tpidr_ff;
   logic [DataW-1:0] tpidrro_ff;
   logic [HalfW-1:0] fpcr_ff;
   logic [HalfW-1:0] fpsr_ff;
   logic [FlagW-1:0] flags_ff;

   // vector file: one memory per element, valid bits stand in for the zero reset
   logic [DataW-1:0]   elem0_mem [NumRegs];
   logic [DataW-1:0]   elem1_mem [NumRegs];
   logic [NumRegs-1:0] vld0_ff;
   logic [NumRegs-1:0] vld1_ff;

   // execute stage
   logic             s1_valid_ff, s1_valid_in;
   logic [DataW-1:0] s1_scalar_ff;
   logic             s1_vec_rd_ff;
   logic             s1_elem_sel_ff;
   logic             s1_two_ff;
   logic             s1_narrow_ff;
   logic             s1_ct_ff;
   logic             s1_fault_ff;
   logic [DataW-1:0] s1_e0_ff;
   logic [DataW-1:0] s1_e1_ff;
   logic             s1_v0_ff;
   logic             s1_v1_ff;

   // output register
   logic             out_valid_ff, out_valid_in;
   logic [DataW-1:0] out_r0_ff, out_r0_in;
   logic [DataW-1:0] out_r1_ff, out_r1_in;
   logic             out_ct_ff;
   logic             out_fault_ff;

   logic             pop, s1_adv, wr_go;
   logic [DataW-1:0] scalar_rd;
   logic [DataW-1:0] e0, e1, r0_raw;

   function automatic logic cond_holds(input logic [FlagW-1:0] f, input cond_type cc);
      logic n, z, c, v, res;
      n = f[3];
      z = f[2];
      c = f[1];
      v = f[0];
      unique case (cc)
         CC_EQ: res = z;
         CC_NE: res = ~z;
         CC_HS: res = c;
         CC_LO: res = ~c;
         CC_MI: res = n;
         CC_PL: res = ~n;
         CC_VS: res = v;
         CC_VC: res = ~v;
         CC_HI: res = c & ~z;
         CC_LS: res = ~c | z;
         CC_GE: res = (n == v);
         CC_LT: res = (n != v);
         CC_GT: res = ~z & (n == v);
         CC_LE: res = z | (n != v);
         CC_AL, CC_NV: res = 1'b1;
         default: res = 1'b1;
      endcase
      return res;
   endfunction

   assign s1_adv    = s1_valid_ff & (~out_valid_ff | rsp_ch.ready);
   assign pop_ready = ~s1_valid_ff | s1_adv;
   assign pop       = pop_valid & pop_ready;
   assign wr_go     = pop & pop_cmd.wr;

   always_comb begin
      scalar_rd = '0;
      unique case (pop_cmd.kind)
         KIND_GP:      scalar_rd = gp_ff[pop_cmd.addr];
         KIND_PC:      scalar_rd = pc_ff;
         KIND_TPIDR:   scalar_rd = tpidr_ff;
         KIND_TPIDRRO: scalar_rd = tpidrro_ff;
         KIND_FPCR:    scalar_rd = {{(DataW-HalfW){1'b0}}, fpcr_ff};
         KIND_FPSR:    scalar_rd = {{(DataW-HalfW){1'b0}}, fpsr_ff};
         default:      scalar_rd = '0;
      endcase
      if (pop_cmd.wr) begin
         scalar_rd = '0;
      end
   end

   // scalar state and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) begin
            gp_ff[i] <= '0;
         end
         pc_ff      <= '0;
         tpidr_ff   <= '0;
         tpidrro_ff <= '0;
         fpcr_ff    <= '0;
         fpsr_ff    <= '0;
         flags_ff   <= '0;
      end else if (pop) begin
         if (pop_cmd.kind == KIND_FLAGS) begin
            flags_ff <= pop_cmd.arg;
         end
         if (pop_cmd.wr) begin
            unique case (pop_cmd.kind)
               KIND_GP:      gp_ff[pop_cmd.addr] <= pop_cmd.d0;
               KIND_PC:      pc_ff      <= pop_cmd.d0;
               KIND_TPIDR:   tpidr_ff   <= pop_cmd.d0;
               KIND_TPIDRRO: tpidrro_ff <= pop_cmd.d0;
               KIND_FPCR:    fpcr_ff    <= pop_cmd.d0[HalfW-1:0];
               KIND_FPSR:    fpsr_ff    <= pop_cmd.d0[HalfW-1:0];
               default: ;
            endcase
         end
      end
   end

   // vector memories
   always_ff @(posedge clock) begin
      if (wr_go && pop_cmd.kind == KIND_VEC && pop_cmd.we0) begin
         elem0_mem[pop_cmd.addr] <= pop_cmd.d0;
      end
      if (wr_go && pop_cmd.kind == KIND_VEC && pop_cmd.we1) begin
         elem1_mem[pop_cmd.addr] <= pop_cmd.d1;
      end
      if (pop) begin
         s1_e0_ff <= elem0_mem[pop_cmd.addr];
         s1_e1_ff <= elem1_mem[pop_cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= '0;
         vld1_ff <= '0;
      end else if (wr_go && pop_cmd.kind == KIND_VEC) begin
         if (pop_cmd.we0) begin
            vld0_ff[pop_cmd.addr] <= 1'b1;
         end
         if (pop_cmd.we1) begin
            vld1_ff[pop_cmd.addr] <= 1'b1;
         end
      end
   end

   // execute stage
   assign s1_valid_in = pop | (s1_valid_ff & ~s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_scalar_ff   <= scalar_rd;
         s1_vec_rd_ff   <= (pop_cmd.kind == KIND_VEC) & ~pop_cmd.wr;
         s1_elem_sel_ff <= pop_cmd.elem_sel;
         s1_two_ff      <= pop_cmd.two;
         s1_narrow_ff   <= pop_cmd.narrow;
         s1_ct_ff       <= (pop_cmd.kind == KIND_COND) &
                           cond_holds(flags_ff, cond_type'(pop_cmd.arg));
         s1_fault_ff    <= (pop_cmd.kind == KIND_FAULT);
         s1_v0_ff       <= vld0_ff[pop_cmd.addr];
         s1_v1_ff       <= vld1_ff[pop_cmd.addr];
      end
   end

   // result assembly
   always_comb begin
      e0     = s1_v0_ff ? s1_e0_ff : '0;
      e1     = s1_v1_ff ? s1_e1_ff : '0;
      r0_raw = s1_vec_rd_ff ? (s1_elem_sel_ff ? e1 : e0) : s1_scalar_ff;
      out_r0_in = s1_narrow_ff ? {{(DataW-HalfW){1'b0}}, r0_raw[HalfW-1:0]} : r0_raw;
      out_r1_in = (s1_vec_rd_ff & s1_two_ff) ? e1 : '0;
   end

   assign out_valid_in = s1_adv | (out_valid_ff & ~rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_r0_ff    <= out_r0_in;
         out_r1_ff    <= out_r1_in;
         out_ct_ff    <= s1_ct_ff;
         out_fault_ff <= s1_fault_ff;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.read_elem0     = out_r0_ff;
   assign rsp_ch.read_elem1     = out_r1_ff;
   assign rsp_ch.condition_true = out_ct_ff;
   assign rsp_ch.fault          = out_fault_ff;

endmodule

// ===== sv/arm64_register_file_views.sv =====
// register file of a 64-bit processor with typed views: 31 general registers plus sp,
// 32 vector registers of two 64-bit elements, pc, two thread id registers, fpcr, fpsr
// and the nzcv flags. every request transaction is a read, a write, a flag update or a
// condition test and produces exactly one response transaction, in order. narrow writes
// (w32, s, d, v8b) zero the bits above them; w/x with index 31 and view code 15 report
// fault and leave all state alone. one transaction is accepted per cycle sustained while
// the response side keeps up. the accepting edge writes the command queue; the command
// then executes against the state, with the registered vector-memory read, into the
// execute register and then loads the output register, from which the response is
// offered. the queue depth plus the execute and output registers set how many requests
// are taken while the response side is stalled. all state reads as zero after reset,
// with no clearing pass.
module arm64_register_file_views import rfv_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic      clock,
   input  logic      reset,
   rfv_req_if.sink   req_ch,
   rfv_rsp_if.source rsp_ch
);

   // front to queue
   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;

   // queue to back
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   // front: classifies view, index and operation into a command
   rfv_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // short command queue so the request side keeps moving while responses stall
   rfv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // back: owns the state, executes commands and holds the response register
   rfv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== tb/sv/arm64_register_file_views_test.sv =====
`timescale 1ns / 100ps

module arm64_register_file_views_test;
   import rfv_pkg::*;

   // view code fifteen has no name in the package
   localparam logic [3:0] VIEW_UNUSED = 4'd15;
   localparam int unsigned NumVecElems = 64;
   localparam int unsigned RandomAccesses = 1620;
   // receiver hold-off that backs the block up into its request port
   localparam int unsigned HoldOffCycles = 120;

   // one request transaction
   typedef struct {
      op_type      op;
      logic [3:0]  view;
      logic [4:0]  reg_index;
      logic        element_index;
      logic [63:0] d0;
      logic [63:0] d1;
      logic [3:0]  nzcv;
      logic [3:0]  cc;
   } access_type;

   // one response transaction
   typedef struct packed {
      logic [63:0] r0;
      logic [63:0] r1;
      logic        ct;
      logic        fault;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rfv_req_if req_ch ();
   rfv_rsp_if rsp_ch ();

   arm64_register_file_views dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // architectural state as the testbench sees it
   logic [63:0] gp_regs [NumRegs];
   logic [63:0] vec_elems [NumVecElems];
   logic [63:0] pc_reg;
   logic [63:0] tpidr_reg;
   logic [63:0] tpidrro_reg;
   logic [31:0] fpcr_reg;
   logic [31:0] fpsr_reg;
   logic [3:0]  nzcv_reg;

   access_type  access_queue [$];      // stimulus not yet offered
   outcome_type rf_responses_due [$];  // predicted responses, oldest first

   access_type  req_now;
   int unsigned accepted = 0;
   int unsigned answered = 0;
   int unsigned failures = 0;
   int unsigned req_wait = 0;
   int unsigned req_mode = 0;
   int unsigned rsp_stall = 0;
   int unsigned rsp_mode = 0;
   int unsigned rsp_hold = 0;

   // condition codes evaluated on n, z, c, v
   function automatic logic cond_met(logic [3:0] cc, logic [3:0] f);
      logic n, z, c, v;
      n = f[3];
      z = f[2];
      c = f[1];
      v = f[0];
      case (cc)
         CC_EQ: return z;
         CC_NE: return !z;
         CC_HS: return c;
         CC_LO: return !c;
         CC_MI: return n;
         CC_PL: return !n;
         CC_VS: return v;
         CC_VC: return !v;
         CC_HI: return c && !z;
         CC_LS: return !c || z;
         CC_GE: return n == v;
         CC_LT: return n != v;
         CC_GT: return !z && (n == v);
         CC_LE: return z || (n != v);
         default: return 1'b1;   // always and never both hold
      endcase
   endfunction

   // applies one access to the state and returns what the block must answer
   function automatic outcome_type rf_access(access_type a);
      outcome_type o;
      logic        wr;
      logic [5:0]  lo;
      logic [5:0]  hi;
      o  = '0;
      wr = (a.op == OP_WRITE);
      lo = {a.reg_index, 1'b0};
      hi = {a.reg_index, 1'b1};
      case (a.op)
         OP_SET_FLAGS: nzcv_reg = a.nzcv;
         OP_TEST:      o.ct = cond_met(a.cc, nzcv_reg);
         default: begin
            case (a.view)
               VIEW_W32, VIEW_X64: begin
                  if (a.reg_index == SpSlot) begin
                     o.fault = 1'b1;
                  end else if (wr) begin
                     gp_regs[a.reg_index] = (a.view == VIEW_W32) ? {32'd0, a.d0[31:0]} : a.d0;
                  end else begin
                     o.r0 = (a.view == VIEW_W32) ? {32'd0, gp_regs[a.reg_index][31:0]}
                                                 : gp_regs[a.reg_index];
                  end
               end
               VIEW_SP: begin
                  if (wr) gp_regs[SpSlot] = a.d0;
                  else o.r0 = gp_regs[SpSlot];
               end
               VIEW_ZERO: ;
               VIEW_PC: begin
                  if (wr) pc_reg = a.d0;
                  else o.r0 = pc_reg;
               end
               VIEW_TPIDR: begin
                  if (wr) tpidr_reg = a.d0;
                  else o.r0 = tpidr_reg;
               end
               VIEW_TPIDRRO: begin
                  if (wr) tpidrro_reg = a.d0;
                  else o.r0 = tpidrro_reg;
               end
               VIEW_FPCR: begin
                  if (wr) fpcr_reg = a.d0[31:0];
                  else o.r0 = {32'd0, fpcr_reg};
               end
               VIEW_FPSR: begin
                  if (wr) fpsr_reg = a.d0[31:0];
                  else o.r0 = {32'd0, fpsr_reg};
               end
               VIEW_S: begin
                  if (wr) begin
                     vec_elems[lo] = {32'd0, a.d0[31:0]};
                     vec_elems[hi] = '0;
                  end else begin
                     o.r0 = {32'd0, vec_elems[lo][31:0]};
                  end
               end
               VIEW_D, VIEW_V8B: begin
                  if (wr) begin
                     vec_elems[lo] = a.d0;
                     vec_elems[hi] = '0;
                  end else begin
                     o.r0 = vec_elems[lo];
                  end
               end
               VIEW_Q, VIEW_V2D: begin
                  if (wr) begin
                     vec_elems[lo] = a.d0;
                     // v2d replicates element 0 into both halves
                     vec_elems[hi] = (a.view == VIEW_Q) ? a.d1 : a.d0;
                  end else begin
                     o.r0 = vec_elems[lo];
                     o.r1 = vec_elems[hi];
                  end
               end
               VIEW_VDELEM: begin
                  if (wr) vec_elems[{a.reg_index, a.element_index}] = a.d0;
                  else o.r0 = vec_elems[{a.reg_index, a.element_index}];
               end
               default: o.fault = 1'b1;
            endcase
         end
      endcase
      return o;
   endfunction

   // gap or stall length for one transaction under the current idling mode
   function automatic int unsigned idle_cycles(int unsigned mode);
      case (mode)
         0: return 0;
         1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
         default: return $urandom_range(0, 13);
      endcase
   endfunction

   // corner values mixed with fully random words
   function automatic logic [63:0] pick_data();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return 64'h0000_0000_FFFF_FFFF;
         4: return 64'hFFFF_FFFF_0000_0000;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // a few hot registers so that reads land on recently written entries
   function automatic logic [4:0] pick_index();
      case ($urandom_range(0, 7))
         0: return 5'd0;
         1: return 5'd1;
         2: return 5'd30;
         3: return 5'd31;
         default: return 5'($urandom_range(0, 31));
      endcase
   endfunction

   function automatic access_type random_access();
      access_type  t;
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 7)       t.op = OP_READ;
      else if (pick < 14) t.op = OP_WRITE;
      else if (pick < 16) t.op = OP_SET_FLAGS;
      else                t.op = OP_TEST;
      t.view          = ($urandom_range(0, 31) == 0) ? VIEW_UNUSED : 4'($urandom_range(0, 14));
      t.reg_index     = pick_index();
      t.element_index = 1'($urandom_range(0, 1));
      t.d0            = pick_data();
      t.d1            = pick_data();
      t.nzcv          = 4'($urandom_range(0, 15));
      t.cc            = 4'($urandom_range(0, 15));
      return t;
   endfunction

   task automatic queue_access(op_type op, logic [3:0] view, logic [4:0] idx, logic el,
                               logic [63:0] d0, logic [63:0] d1, logic [3:0] nzcv,
                               logic [3:0] cc);
      access_type t;
      t.op            = op;
      t.view          = view;
      t.reg_index     = idx;
      t.element_index = el;
      t.d0            = d0;
      t.d1            = d1;
      t.nzcv          = nzcv;
      t.cc            = cc;
      access_queue.push_back(t);
   endtask

   // request side: one transaction per handshake, random gaps in between
   always @(posedge clock) begin : req_side
      logic offer;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         offer = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            rf_responses_due.push_back(rf_access(req_now));
            accepted++;
            offer = 1'b0;
            if (accepted % 50 == 0) req_mode = $urandom_range(0, 2);
            req_wait = idle_cycles(req_mode);
         end
         if (!offer) begin
            if (req_wait != 0) begin
               req_wait--;
            end else if (access_queue.size() != 0) begin
               req_now = access_queue.pop_front();
               offer   = 1'b1;
               req_ch.op             <= req_now.op;
               req_ch.view           <= req_now.view;
               req_ch.reg_index      <= req_now.reg_index;
               req_ch.element_index  <= req_now.element_index;
               req_ch.write_elem0    <= req_now.d0;
               req_ch.write_elem1    <= req_now.d1;
               req_ch.nzcv_in        <= req_now.nzcv;
               req_ch.condition_code <= req_now.cc;
            end
         end
         req_ch.valid <= offer;
      end
   end

   // response side: compare against the oldest prediction, stall at random
   always @(posedge clock) begin : rsp_side
      outcome_type want;
      logic        rdy;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (rf_responses_due.size() == 0) begin
               $error("response transaction with no request outstanding");
               failures++;
            end else begin
               want = rf_responses_due.pop_front();
               if (rsp_ch.read_elem0 !== want.r0) begin
                  $error("read_elem0 expected %h got %h", want.r0, rsp_ch.read_elem0);
                  failures++;
               end
               if (rsp_ch.read_elem1 !== want.r1) begin
                  $error("read_elem1 expected %h got %h", want.r1, rsp_ch.read_elem1);
                  failures++;
               end
               if (rsp_ch.condition_true !== want.ct) begin
                  $error("condition_true expected %b got %b", want.ct, rsp_ch.condition_true);
                  failures++;
               end
               if (rsp_ch.fault !== want.fault) begin
                  $error("fault expected %b got %b", want.fault, rsp_ch.fault);
                  failures++;
               end
            end
            answered++;
            if (answered % 50 == 0) rsp_mode = $urandom_range(0, 2);
            rsp_stall = idle_cycles(rsp_mode);
            // long hold-offs: requests keep coming until the block backs up
            if (answered == 300 || answered == 1100) rsp_hold = HoldOffCycles;
         end
         if (rsp_hold != 0) begin
            rsp_hold--;
            rdy = 1'b0;
         end else if (rsp_stall != 0) begin
            rsp_stall--;
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
         end
         rsp_ch.ready <= rdy;
      end
   end

   initial begin
      int unsigned total;
      req_ch.valid          = 1'b0;
      req_ch.op             = OP_READ;
      req_ch.view           = VIEW_W32;
      req_ch.reg_index      = '0;
      req_ch.element_index  = 1'b0;
      req_ch.write_elem0    = '0;
      req_ch.write_elem1    = '0;
      req_ch.nzcv_in        = '0;
      req_ch.condition_code = CC_EQ;
      rsp_ch.ready          = 1'b0;
      req_now               = '{op: OP_READ, default: '0};

      // state right after reset
      foreach (gp_regs[i]) gp_regs[i] = '0;
      foreach (vec_elems[i]) vec_elems[i] = '0;
      pc_reg      = '0;
      tpidr_reg   = '0;
      tpidrro_reg = '0;
      fpcr_reg    = '0;
      fpsr_reg    = '0;
      nzcv_reg    = '0;

      // general registers: narrow read, narrow write clears the top half, index 31 faults
      queue_access(OP_WRITE, VIEW_X64, 5'd0, 1'b0, '1, '0, '0, CC_EQ);
      queue_access(OP_READ,  VIEW_W32, 5'd0, 1'b0, '0, '0, '0, CC_EQ);
      queue_access(OP_WRITE, VIEW_W32, 5'd30, 1'b0, '1, '1, '0, CC_EQ);
      queue_access(OP_READ,  VIEW_X64, 5'd30, 1'b0, '0, '0, '0, CC_EQ);
      queue_access(OP_WRITE, VIEW_X64, 5'd31, 1'b0, '1, '1, '0, CC_EQ);
      queue_access(OP_READ,  VIEW_W32, 5'd31, 1'b0, '0, '0, '0, CC_EQ);
      // unused view code faults both ways
      queue_access(OP_WRITE, VIEW_UNUSED, 5'd3, 1'b1, '1, '1, '1, CC_NV);
      queue_access(OP_READ,  VIEW_UNUSED, 5'd3, 1'b0, '0, '0, '0, CC_EQ);
      // single registers ignore the index; zero view discards writes
      queue_access(OP_WRITE, VIEW_SP, 5'd7, 1'b0, 64'h8000_0000_0000_0001, '0, '0, CC_EQ);
      queue_access(OP_READ,  VIEW_SP, 5'd12, 1'b1, '0, '0, '0, CC_EQ);
      queue_access(OP_WRITE, VIEW_ZERO, 5'd31, 1'b0, '1, '1, '0, CC_EQ);
      queue_access(OP_READ,  VIEW_ZERO, 5'd0, 1'b0, '0, '0, '0, CC_EQ);
      queue_access(OP_WRITE, VIEW_PC, 5'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFC, '0, '0, CC_EQ);
      queue_access(OP_WRITE, VIEW_TPIDR, 5'd0, 1'b0, 64'h0123_4567_89AB_CDEF, '0, '0, CC_EQ);
      queue_access(OP_WRITE, VIEW_TPIDRRO, 5'd31, 1'b0, 64'hFEDC_BA98_7654_3210, '0, '0, CC_EQ);
      queue_access(OP_WRITE, VIEW_FPCR, 5'd0, 1'b0, '1, '0, '0, CC_EQ);
      queue_access(OP_WRITE, VIEW_FPSR, 5'd0, 1'b0, 64'hAAAA_AAAA_5555_5555, '0, '0, CC_EQ);
      queue_access(OP_READ,  VIEW_PC, 5'd0, 1'b0, '0, '0, '0, CC_EQ);
      queue_access(OP_READ,  VIEW_TPIDR, 5'd0, 1'b0, '0, '0, '0, CC_EQ);
      queue_access(OP_READ,  VIEW_TPIDRRO, 5'd0, 1'b0, '0, '0, '0, CC_EQ);
      queue_access(OP_READ,  VIEW_FPCR, 5'd0, 1'b0, '0, '0, '0, CC_EQ);
      queue_access(OP_READ,  VIEW_FPSR, 5'd0, 1'b0, '0, '0, '0, CC_EQ);
      // vector views: full write, s write clears above 32 bits, replicate, element select
      queue_access(OP_WRITE, VIEW_Q, 5'd31, 1'b0, '1, '1, '0, CC_EQ);
      queue_access(OP_WRITE, VIEW_S, 5'd31, 1'b0, '1, '1, '0, CC_EQ);
      queue_access(OP_READ,  VIEW_Q, 5'd31, 1'b0, '0, '0, '0, CC_EQ);
      queue_access(OP_WRITE, VIEW_V2D, 5'd0, 1'b1, 64'h1111_2222_3333_4444, '1, '0, CC_EQ);
      queue_access(OP_WRITE, VIEW_VDELEM, 5'd0, 1'b1, 64'h5555_6666_7777_8888, '0, '0, CC_EQ);
      queue_access(OP_READ,  VIEW_V2D, 5'd0, 1'b0, '0, '0, '0, CC_EQ);
      queue_access(OP_WRITE, VIEW_V8B, 5'd1, 1'b0, '1, '1, '0, CC_EQ);
      queue_access(OP_READ,  VIEW_D, 5'd1, 1'b0, '0, '0, '0, CC_EQ);
      queue_access(OP_READ,  VIEW_VDELEM, 5'd1, 1'b1, '0, '0, '0, CC_EQ);
      // flags: always and never hold on clear flags; set flags never faults
      queue_access(OP_TEST, VIEW_UNUSED, 5'd31, 1'b0, '0, '0, '0, CC_AL);
      queue_access(OP_TEST, VIEW_W32, 5'd31, 1'b0, '0, '0, '0, CC_NV);
      queue_access(OP_SET_FLAGS, VIEW_UNUSED, 5'd31, 1'b1, '1, '1, 4'b1001, CC_EQ);
      queue_access(OP_TEST, VIEW_X64, 5'd31, 1'b0, '0, '0, '0, CC_MI);

      repeat (RandomAccesses) access_queue.push_back(random_access());
      total = access_queue.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (accepted < total) @(posedge clock);
      while (rf_responses_due.size() != 0) @(posedge clock);
      // wait on past the pipeline depth to catch stray responses
      repeat (12) @(posedge clock);

      if (failures == 0 && rf_responses_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/rfv_pkg.sv
sv/rfv_if.sv
sv/rfv_front.sv
sv/rfv_queue.sv
sv/rfv_back.sv
sv/arm64_register_file_views.sv
tb/sv/arm64_register_file_views_test.sv
